[rtl/v3au_pkg.sv]
// shared types and constants of the three-component vector unit
`default_nettype none

package v3au_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        OP_DOT   = 3'd0,
        OP_CROSS = 3'd1,
        OP_SCALE = 3'd2,
        OP_ADD   = 3'd3,
        OP_MAG   = 3'd4,
        OP_NORM  = 3'd5
    } t_op;

endpackage

`default_nettype wire

[rtl/v3au_lane.sv]
// one component lane: two products, their difference, sum and absolute value
`default_nettype none

module v3au_lane
    import v3au_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic signed [DATA_W-1:0]     i_x1,
    input  wire logic signed [DATA_W-1:0]     i_y1,
    input  wire logic signed [DATA_W-1:0]     i_x2,
    input  wire logic signed [DATA_W-1:0]     i_y2,
    input  wire logic signed [DATA_W-1:0]     i_a,
    input  wire logic signed [DATA_W-1:0]     i_b,
    output logic signed [2*DATA_W-1:0]        o_p1,
    output logic signed [2*DATA_W:0]          o_d,
    output logic signed [DATA_W:0]            o_add,
    output logic        [DATA_W-1:0]          o_ua,
    output logic                              o_neg
);

    logic signed [2*DATA_W-1:0] r_p1, r_p2, r_p1b;
    logic signed [2*DATA_W:0]   r_d;
    logic signed [DATA_W:0]     r_add, r_add2;
    logic        [DATA_W-1:0]   r_ua, r_ua2;
    logic                       r_neg, r_neg2;
    logic signed [DATA_W:0]     n_abs;

    assign n_abs = i_a[DATA_W-1] ? -(DATA_W+1)'(i_a) : (DATA_W+1)'(i_a);

    // products first, difference one stage later
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1   <= (2*DATA_W)'(i_x1) * (2*DATA_W)'(i_y1);
            r_p2   <= (2*DATA_W)'(i_x2) * (2*DATA_W)'(i_y2);
            r_add  <= (DATA_W+1)'(i_a) + (DATA_W+1)'(i_b);
            r_ua   <= n_abs[DATA_W-1:0];
            r_neg  <= i_a[DATA_W-1];
            r_p1b  <= r_p1;
            r_d    <= (2*DATA_W+1)'(r_p1) - (2*DATA_W+1)'(r_p2);
            r_add2 <= r_add;
            r_ua2  <= r_ua;
            r_neg2 <= r_neg;
        end
    end

    assign o_p1  = r_p1b;
    assign o_d   = r_d;
    assign o_add = r_add2;
    assign o_ua  = r_ua2;
    assign o_neg = r_neg2;

endmodule

`default_nettype wire

[rtl/v3au_sqrt.sv]
// pipelined integer square root, one result bit per stage
`default_nettype none

module v3au_sqrt
    import v3au_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic [2*DATA_W-1:0]     i_rad,
    output logic      [DATA_W-1:0]       o_root
);

    localparam int STEPS = DATA_W;
    localparam int RW    = 2 * DATA_W;

    logic [RW-1:0] r_x [STEPS];
    logic [RW-1:0] r_r [STEPS];

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2 * s);
        logic [RW-1:0] x_in, r_in, trial, n_x, n_r;
        logic          ge;

        if (s == 0) begin : g_first
            assign x_in = i_rad;
            assign r_in = '0;
        end else begin : g_next
            assign x_in = r_x[s-1];
            assign r_in = r_r[s-1];
        end

        always_comb begin
            trial = r_in + BIT;
            ge    = (x_in >= trial);
            n_x   = ge ? (x_in - trial) : x_in;
            n_r   = ge ? ((r_in >> 1) + BIT) : (r_in >> 1);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[s] <= n_x;
                r_r[s] <= n_r;
            end
        end
    end

    assign o_root = r_r[STEPS-1][DATA_W-1:0];

endmodule

`default_nettype wire

[rtl/v3au_div.sv]
// pipelined restoring divider for normalise, one quotient bit per stage
`default_nettype none

module v3au_div
    import v3au_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [DATA_W-1:0]     i_ua,
    input  wire logic [DATA_W-1:0]     i_mag,
    output logic      [FRAC_BITS:0]    o_q
);

    localparam int DW = DATA_W + FRAC_BITS;
    localparam int NS = FRAC_BITS + 1;

    logic [DW-1:0]     r_rem [NS];
    logic [FRAC_BITS:0] r_q  [NS];
    logic [DATA_W-1:0] r_mag [FRAC_BITS];

    // |a| <= magnitude, so the quotient never exceeds one in fixed point
    for (genvar s = 0; s < NS; s++) begin : g_step
        localparam int B = FRAC_BITS - s;
        logic [DW-1:0]      rem_in, dvs, n_rem;
        logic [FRAC_BITS:0] q_in, n_q;
        logic [DATA_W-1:0]  mag_in;
        logic               ge;

        if (s == 0) begin : g_first
            assign rem_in = {i_ua, FRAC_BITS'(0)};
            assign q_in   = '0;
            assign mag_in = i_mag;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign q_in   = r_q[s-1];
            assign mag_in = r_mag[s-1];
        end

        always_comb begin
            dvs   = DW'(mag_in) << B;
            ge    = (rem_in >= dvs);
            n_rem = ge ? (rem_in - dvs) : rem_in;
            n_q   = ge ? (q_in | ((FRAC_BITS+1)'(1) << B)) : q_in;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_q[s]   <= n_q;
            end
        end

        if (s < NS - 1) begin : g_mag
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_mag[s] <= mag_in;
                end
            end
        end
    end

    assign o_q = r_q[NS-1];

endmodule

`default_nettype wire

[rtl/vector3_arithmetic_unit.sv]
// top level of the three-component vector unit: lanes, merge, root, divide, output
//
// channel  dir  signals                     contents
// s        in   i_s_tvalid/o_s_tready       tdata: a_i a_j a_k b_i b_j b_k scale_factor
//                                           tuser: req_type
// m        out  o_m_tvalid/i_m_tready       tdata: res_i res_j res_k res_scalar
//                                           tuser: saturated zero_length
//
// one item per cycle unless the output stalls; the depth is set by the 32-stage
// square root pipeline followed by the FRAC_BITS + 1 stage divider
// every operation goes the full depth so results leave in arrival order
// reset clears the stage valid bits only, input not ready while in reset
// the whole pipeline holds while the output item waits to be taken
`default_nettype none

module vector3_arithmetic_unit
    import v3au_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    // a_i, a_j, a_k, b_i, b_j, b_k, scale_factor from bit 0 up
    input  wire logic [223:0]    i_s_tdata,
    // req_type
    input  wire logic [2:0]      i_s_tuser,
    output logic                 o_m_tvalid,
    input  wire logic            i_m_tready,
    // res_i, res_j, res_k, res_scalar from bit 0 up
    output logic [127:0]         o_m_tdata,
    // saturated, zero_length from bit 0 up
    output logic [1:0]           o_m_tuser
);

    localparam int ROOT_N = DATA_W;
    localparam int DIV_N  = FRAC_BITS + 1;
    localparam int NV     = 3 + ROOT_N + DIV_N + 1;
    localparam logic signed [65:0] W_HI = (66'sd1 <<< (WORD_BITS - 1)) - 66'sd1;
    localparam logic signed [65:0] W_LO = -W_HI - 66'sd1;

    typedef struct packed {
        logic [2:0]              op;
        logic [3:0][DATA_W-1:0]  res;
        logic                    sat;
        logic [2:0][DATA_W-1:0]  ua;
        logic [2:0]              neg;
    } t_mid;

    typedef struct packed {
        logic [2:0]              op;
        logic [3:0][DATA_W-1:0]  res;
        logic                    sat;
        logic [2:0]              neg;
        logic [DATA_W-1:0]       mag;
    } t_late;

    // saturate to the word range, returns {clamped flag, low field bits}
    function automatic logic [DATA_W:0] f_clamp(input logic signed [65:0] v);
        logic [DATA_W:0] r;
        if (v > W_HI) begin
            r = {1'b1, W_HI[DATA_W-1:0]};
        end else if (v < W_LO) begin
            r = {1'b1, W_LO[DATA_W-1:0]};
        end else begin
            r = {1'b0, v[DATA_W-1:0]};
        end
        return r;
    endfunction

    logic              w_en;
    logic [NV-1:0]     r_vld;

    logic signed [DATA_W-1:0] w_a [3];
    logic signed [DATA_W-1:0] w_b [3];
    logic signed [DATA_W-1:0] w_s;
    logic [2:0]               w_op;

    logic signed [2*DATA_W-1:0] w_p1  [3];
    logic signed [2*DATA_W:0]   w_d   [3];
    logic signed [DATA_W:0]     w_add [3];
    logic        [DATA_W-1:0]   w_ua  [3];
    logic                       w_neg [3];

    logic [2:0] r_op1, r_op2;

    // merge stage
    logic [2:0]               r_m_op;
    logic signed [65:0]       r_m_sum;
    logic signed [2*DATA_W:0] r_m_d   [3];
    logic signed [DATA_W:0]   r_m_add [3];
    logic [DATA_W-1:0]        r_m_ua  [3];
    logic                     r_m_neg [3];

    t_mid              n_mid;
    t_mid              r_mid  [ROOT_N];
    t_late             r_late [DIV_N];
    logic [DATA_W-1:0] w_mag;
    logic [FRAC_BITS:0] w_q [3];

    logic [127:0]      r_out_data, n_out_data;
    logic [1:0]        r_out_user, n_out_user;

    assign w_en       = !r_vld[NV-1] || i_m_tready;
    assign o_s_tready = w_en && i_rst_n;
    assign o_m_tvalid = r_vld[NV-1];
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NV-2:0], i_s_tvalid};
        end
    end

    // unpack the input item
    for (genvar l = 0; l < 3; l++) begin : g_unpack
        assign w_a[l] = i_s_tdata[l*DATA_W +: DATA_W];
        assign w_b[l] = i_s_tdata[(l+3)*DATA_W +: DATA_W];
    end
    assign w_s  = i_s_tdata[6*DATA_W +: DATA_W];
    assign w_op = i_s_tuser;

    // operand selection and the three lanes
    for (genvar l = 0; l < 3; l++) begin : g_lane
        localparam int J = (l + 1) % 3;
        localparam int K = (l + 2) % 3;
        logic signed [DATA_W-1:0] x1, y1, x2, y2;

        always_comb begin
            x1 = w_a[l];
            y1 = w_a[l];
            x2 = '0;
            y2 = '0;
            case (w_op)
                OP_DOT: begin
                    y1 = w_b[l];
                end
                OP_CROSS: begin
                    x1 = w_a[J];
                    y1 = w_b[K];
                    x2 = w_a[K];
                    y2 = w_b[J];
                end
                OP_SCALE: begin
                    y1 = w_s;
                end
                default: begin
                    y1 = w_a[l];
                end
            endcase
        end

        v3au_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x1  (x1),
            .i_y1  (y1),
            .i_x2  (x2),
            .i_y2  (y2),
            .i_a   (w_a[l]),
            .i_b   (w_b[l]),
            .o_p1  (w_p1[l]),
            .o_d   (w_d[l]),
            .o_add (w_add[l]),
            .o_ua  (w_ua[l]),
            .o_neg (w_neg[l])
        );
    end

    // merge: the three-term sum serves dot product and sum of squares
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op1   <= w_op;
            r_op2   <= r_op1;
            r_m_op  <= r_op2;
            r_m_sum <= 66'(w_p1[0]) + 66'(w_p1[1]) + 66'(w_p1[2]);
            for (int l = 0; l < 3; l++) begin
                r_m_d[l]   <= w_d[l];
                r_m_add[l] <= w_add[l];
                r_m_ua[l]  <= w_ua[l];
                r_m_neg[l] <= w_neg[l];
            end
        end
    end

    // results of the operations that need no root, floor by arithmetic shift
    always_comb begin
        logic [DATA_W:0] c;
        c         = '0;
        n_mid     = '0;
        n_mid.op  = r_m_op;
        for (int l = 0; l < 3; l++) begin
            n_mid.ua[l]  = r_m_ua[l];
            n_mid.neg[l] = r_m_neg[l];
        end
        case (r_m_op)
            OP_DOT: begin
                c            = f_clamp(r_m_sum >>> FRAC_BITS);
                n_mid.res[3] = c[DATA_W-1:0];
                n_mid.sat    = c[DATA_W];
            end
            OP_CROSS, OP_SCALE: begin
                for (int l = 0; l < 3; l++) begin
                    c            = f_clamp(66'(r_m_d[l]) >>> FRAC_BITS);
                    n_mid.res[l] = c[DATA_W-1:0];
                    n_mid.sat    = n_mid.sat | c[DATA_W];
                end
            end
            OP_ADD: begin
                for (int l = 0; l < 3; l++) begin
                    c            = f_clamp(66'(r_m_add[l]));
                    n_mid.res[l] = c[DATA_W-1:0];
                    n_mid.sat    = n_mid.sat | c[DATA_W];
                end
            end
            default: begin
                n_mid.sat = 1'b0;
            end
        endcase
    end

    v3au_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_m_sum[2*DATA_W-1:0]),
        .o_root (w_mag)
    );

    // carry the item alongside the root pipeline
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mid[0] <= n_mid;
            for (int s = 1; s < ROOT_N; s++) begin
                r_mid[s] <= r_mid[s-1];
            end
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_div
        v3au_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_ua  (r_mid[ROOT_N-1].ua[l]),
            .i_mag (w_mag),
            .o_q   (w_q[l])
        );
    end

    // and alongside the divider
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_late[0].op  <= r_mid[ROOT_N-1].op;
            r_late[0].res <= r_mid[ROOT_N-1].res;
            r_late[0].sat <= r_mid[ROOT_N-1].sat;
            r_late[0].neg <= r_mid[ROOT_N-1].neg;
            r_late[0].mag <= w_mag;
            for (int s = 1; s < DIV_N; s++) begin
                r_late[s] <= r_late[s-1];
            end
        end
    end

    // final selection for magnitude and normalise
    always_comb begin
        logic [DATA_W:0]    c;
        logic signed [65:0] v;
        logic [3:0][DATA_W-1:0] res;
        logic               sat;
        logic               zl;
        c   = '0;
        v   = '0;
        res = r_late[DIV_N-1].res;
        sat = r_late[DIV_N-1].sat;
        zl  = 1'b0;
        case (r_late[DIV_N-1].op)
            OP_MAG: begin
                c      = f_clamp(66'(r_late[DIV_N-1].mag));
                res    = '0;
                res[3] = c[DATA_W-1:0];
                sat    = c[DATA_W];
            end
            OP_NORM: begin
                res = '0;
                sat = 1'b0;
                if (r_late[DIV_N-1].mag == '0) begin
                    zl = 1'b1;
                end else begin
                    for (int l = 0; l < 3; l++) begin
                        v      = 66'(w_q[l]);
                        v      = r_late[DIV_N-1].neg[l] ? -v : v;
                        c      = f_clamp(v);
                        res[l] = c[DATA_W-1:0];
                        sat    = sat | c[DATA_W];
                    end
                end
            end
            default: begin
                zl = 1'b0;
            end
        endcase
        n_out_data = res;
        n_out_user = {zl, sat};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

endmodule

`default_nettype wire
